// ===== rtl/text_command_line_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Command line parser assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH
`define TEXT_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst is high
`define TCLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("command line parser: same-cycle check failed");

// Next-cycle implication, disabled while rst is high
`define TCLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("command line parser: next-cycle check failed");

`endif

// ===== rtl/tclp_pkg.sv =====
// ----------------------------------------------------------------------------
// Command line parser package
// Queue entry types, command codes and keyword tables.
// ----------------------------------------------------------------------------
package tclp_pkg;

   // Character classes produced by the front end
   localparam logic [1:0] CLASS_TOKEN = 2'd0;
   localparam logic [1:0] CLASS_GAP   = 2'd1;
   localparam logic [1:0] CLASS_END   = 2'd2;

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_SEMI  = 8'd59;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   // Command kinds
   localparam logic [3:0] KIND_ERROR      = 4'd0;
   localparam logic [3:0] KIND_SPEED      = 4'd1;
   localparam logic [3:0] KIND_TARGET     = 4'd2;
   localparam logic [3:0] KIND_QUERY_BASE = 4'd3;
   localparam logic [3:0] KIND_RUN        = 4'd7;
   localparam logic [3:0] KIND_CHARGE     = 4'd9;
   localparam logic [3:0] KIND_LAST       = 4'd13;

   // First-word indexes
   localparam logic [3:0] WORD_SPEED  = 4'd0;
   localparam logic [3:0] WORD_TO     = 4'd1;
   localparam logic [3:0] WORD_QUERY  = 4'd2;
   localparam logic [3:0] WORD_START  = 4'd3;
   localparam logic [3:0] WORD_CHARGE = 4'd5;

   localparam int NUM_FIRST  = 10;
   localparam int NUM_SECOND = 4;

   localparam logic [3:0] POS_MAX = 4'd15;

   // Register indexes
   localparam logic [1:0] CSR_SPEED_HIGH = 2'd0;
   localparam logic [1:0] CSR_SPEED_LOW  = 2'd1;
   localparam logic [1:0] CSR_CHARGE_ID  = 2'd2;

   localparam logic [30:0] SPEED_HIGH_RESET = 31'd1000;

   typedef struct packed {
      logic [1:0] char_class;
      logic [7:0] char_byte;
      logic       line_long;
   } tclp_entry_type;

   typedef struct packed {
      logic [3:0]         command_kind;
      logic signed [31:0] command_value;
   } tclp_result_type;

   // Character at pos of a right-justified word of n characters
   function automatic logic [7:0] word_char(input logic [63:0] w, input logic [3:0] n,
                                           input logic [3:0] pos);
      logic [2:0] idx;
      idx = 3'(n - 4'd1 - pos);
      return w[8*idx +: 8];
   endfunction

   function automatic logic [3:0] first_len(input logic [3:0] k);
      logic [3:0] n;
      case (k)
         4'd0:    n = 4'd5;
         4'd1:    n = 4'd2;
         4'd2:    n = 4'd5;
         4'd3:    n = 4'd5;
         4'd4:    n = 4'd4;
         4'd5:    n = 4'd6;
         4'd6:    n = 4'd7;
         4'd7:    n = 4'd4;
         4'd8:    n = 4'd4;
         4'd9:    n = 4'd5;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] first_char(input logic [3:0] k, input logic [3:0] pos);
      logic [63:0] w;
      case (k)
         4'd0:    w = 64'("speed");
         4'd1:    w = 64'("to");
         4'd2:    w = 64'("query");
         4'd3:    w = 64'("start");
         4'd4:    w = 64'("stop");
         4'd5:    w = 64'("charge");
         4'd6:    w = 64'("forward");
         4'd7:    w = 64'("back");
         4'd8:    w = 64'("left");
         4'd9:    w = 64'("right");
         default: w = 64'd0;
      endcase
      return word_char(w, first_len(k), pos);
   endfunction

   function automatic logic [3:0] second_len(input logic [1:0] k);
      logic [3:0] n;
      case (k)
         2'd0:    n = 4'd5;
         2'd1:    n = 4'd5;
         2'd2:    n = 4'd6;
         2'd3:    n = 4'd3;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] second_char(input logic [1:0] k, input logic [3:0] pos);
      logic [63:0] w;
      case (k)
         2'd0:    w = 64'("state");
         2'd1:    w = 64'("speed");
         2'd2:    w = 64'("target");
         2'd3:    w = 64'("all");
         default: w = 64'd0;
      endcase
      return word_char(w, second_len(k), pos);
   endfunction

endpackage

// ===== rtl/tclp_fifo.sv =====
// ----------------------------------------------------------------------------
// Command line parser queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tclp_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntFull);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tclp_front.sv =====
// ----------------------------------------------------------------------------
// Command line parser front end
// Classifies each character and tracks the line length.
// ----------------------------------------------------------------------------
module tclp_front
   import tclp_pkg::*;
#(
   parameter int MaxLine = 256
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   input  logic [7:0]     req_char_byte,
   input  logic           queue_full,
   output logic           queue_push,
   output tclp_entry_type queue_entry
);

   localparam int LenW = $clog2(MaxLine + 1);
   localparam logic [LenW-1:0] LenMax = LenW'(MaxLine);

   logic [LenW-1:0] line_len_ff, line_len_in;
   logic            accept;

   assign accept     = req_push && !queue_full;
   assign queue_push = accept;

   // Classify the request
   always_comb begin
      queue_entry.char_byte = req_char_byte;
      queue_entry.line_long = (line_len_ff >= LenMax);
      case (req_char_byte)
         CHAR_SEMI:  queue_entry.char_class = CLASS_END;
         CHAR_SPACE: queue_entry.char_class = CLASS_GAP;
         default:    queue_entry.char_class = CLASS_TOKEN;
      endcase
   end

   // Count bytes before the terminator, saturating at the limit
   always_comb begin
      line_len_in = line_len_ff;
      if (accept) begin
         if (req_char_byte == CHAR_SEMI) begin
            line_len_in = '0;
         end else if (line_len_ff < LenMax) begin
            line_len_in = line_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
      end else begin
         line_len_ff <= line_len_in;
      end
   end

endmodule

// ===== rtl/tclp_back.sv =====
// ----------------------------------------------------------------------------
// Command line parser back end
// Tokenises, matches keywords, reads numbers and builds each command.
// ----------------------------------------------------------------------------
module tclp_back
   import tclp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_index,
   input  logic [30:0]     csr_write_data,
   input  logic            entry_valid,
   input  tclp_entry_type  entry,
   output logic            entry_pop,
   input  logic            result_full,
   output logic            result_push,
   output tclp_result_type result
);

   logic [30:0] speed_high_ff;
   logic [30:0] speed_low_ff;
   logic [15:0] charge_id_ff;

   logic [1:0]  tok_count_ff, tok_count_in;
   logic        inside_ff, inside_in;
   logic [3:0]  pos_ff, pos_in;
   logic [9:0]  first_ff, first_in;
   logic [3:0]  second_ff, second_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;

   logic        take;
   logic        is_end;

   // Line end also finishes the open token
   logic [1:0]  fin_count;
   logic [9:0]  fin_first;
   logic [3:0]  fin_second;

   assign is_end      = (entry.char_class == CLASS_END);
   assign take        = entry_valid && (!is_end || !result_full);
   assign entry_pop   = take;
   assign result_push = entry_valid && is_end && !result_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_high_ff <= SPEED_HIGH_RESET;
         speed_low_ff  <= '0;
         charge_id_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPEED_HIGH: speed_high_ff <= csr_write_data;
            CSR_SPEED_LOW:  speed_low_ff  <= csr_write_data;
            CSR_CHARGE_ID:  charge_id_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Close the current token against the keyword lengths
   always_comb begin
      fin_count  = tok_count_ff;
      fin_first  = first_ff;
      fin_second = second_ff;
      if (inside_ff) begin
         if (tok_count_ff == 2'd0) begin
            for (int k = 0; k < NUM_FIRST; k++) begin
               if (pos_ff != first_len(4'(k))) fin_first[k] = 1'b0;
            end
         end else if (tok_count_ff == 2'd1) begin
            for (int k = 0; k < NUM_SECOND; k++) begin
               if (pos_ff != second_len(2'(k))) fin_second[k] = 1'b0;
            end
         end
         fin_count = (tok_count_ff < 2'd2) ? tok_count_ff + 2'd1 : 2'd2;
      end
   end

   // Advance the token state for one character
   always_comb begin
      logic [3:0]  pos_b;
      logic [9:0]  first_b;
      logic [3:0]  second_b;
      logic [31:0] acc_b;
      logic        neg_b;
      logic [7:0]  c;
      c        = entry.char_byte;
      pos_b    = inside_ff ? pos_ff : 4'd0;
      first_b  = (!inside_ff && tok_count_ff == 2'd0) ? '1 : first_ff;
      second_b = (!inside_ff && tok_count_ff == 2'd1) ? '1 : second_ff;
      acc_b    = (!inside_ff && tok_count_ff == 2'd1) ? '0 : acc_ff;
      neg_b    = (!inside_ff && tok_count_ff == 2'd1) ? 1'b0 : neg_ff;

      tok_count_in = tok_count_ff;
      inside_in    = inside_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;

      case (entry.char_class)
         CLASS_TOKEN: begin
            inside_in = 1'b1;
            first_in  = first_b;
            second_in = second_b;
            acc_in    = acc_b;
            neg_in    = neg_b;
            pos_in    = pos_b;
            if (tok_count_ff == 2'd0) begin
               for (int k = 0; k < NUM_FIRST; k++) begin
                  if (pos_b >= first_len(4'(k)) || first_char(4'(k), pos_b) != c) begin
                     first_in[k] = 1'b0;
                  end
               end
               if (pos_b < POS_MAX) pos_in = pos_b + 4'd1;
            end else if (tok_count_ff == 2'd1) begin
               for (int k = 0; k < NUM_SECOND; k++) begin
                  if (pos_b >= second_len(2'(k)) || second_char(2'(k), pos_b) != c) begin
                     second_in[k] = 1'b0;
                  end
               end
               if (pos_b == 4'd0 && c == CHAR_MINUS) begin
                  neg_in = 1'b1;
               end else begin
                  acc_in = (acc_b << 3) + (acc_b << 1) + {24'd0, c} - {24'd0, CHAR_ZERO};
               end
               if (pos_b < POS_MAX) pos_in = pos_b + 4'd1;
            end
         end
         CLASS_GAP: begin
            tok_count_in = fin_count;
            first_in     = fin_first;
            second_in    = fin_second;
            inside_in    = 1'b0;
         end
         CLASS_END: begin
            tok_count_in = 2'd0;
            inside_in    = 1'b0;
            pos_in       = 4'd0;
            first_in     = '1;
            second_in    = '1;
            acc_in       = '0;
            neg_in       = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_count_ff <= 2'd0;
         inside_ff    <= 1'b0;
         pos_ff       <= 4'd0;
         first_ff     <= '1;
         second_ff    <= '1;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
      end else if (take) begin
         tok_count_ff <= tok_count_in;
         inside_ff    <= inside_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
      end
   end

   // Build the command at line end
   always_comb begin
      logic        w_valid;
      logic [3:0]  w;
      logic        q_valid;
      logic [1:0]  q;
      logic [31:0] neg_acc;
      logic [31:0] num;
      logic [31:0] mag;
      w_valid = 1'b0;
      w       = 4'd0;
      q_valid = 1'b0;
      q       = 2'd0;
      for (int k = NUM_FIRST - 1; k >= 0; k--) begin
         if (fin_first[k]) begin
            w_valid = 1'b1;
            w       = 4'(k);
         end
      end
      for (int k = NUM_SECOND - 1; k >= 0; k--) begin
         if (fin_second[k]) begin
            q_valid = 1'b1;
            q       = 2'(k);
         end
      end
      neg_acc = 32'd0 - acc_ff;
      num     = neg_ff ? neg_acc : acc_ff;
      mag     = num[31] ? (neg_ff ? acc_ff : neg_acc) : num;

      result.command_kind  = KIND_ERROR;
      result.command_value = '1;
      if (!entry.line_long && fin_count != 2'd0 && w_valid) begin
         if (fin_count == 2'd2) begin
            if (w == WORD_SPEED) begin
               if (!(mag > {1'b0, speed_high_ff}) && !(mag < {1'b0, speed_low_ff})) begin
                  result.command_kind  = KIND_SPEED;
                  result.command_value = num;
               end
            end else if (w == WORD_TO) begin
               result.command_kind  = KIND_TARGET;
               result.command_value = num;
            end else if (w == WORD_QUERY && q_valid) begin
               result.command_kind = KIND_QUERY_BASE + {2'd0, q};
            end
         end else if (w >= WORD_START) begin
            result.command_kind = KIND_RUN + (w - WORD_START);
            if (w == WORD_CHARGE) result.command_value = {16'd0, charge_id_ff};
         end
      end
   end

endmodule

// ===== rtl/text_command_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Text command line parser
// Splits a character stream into lines and emits one command per line.
// ----------------------------------------------------------------------------
//  channel   ports                                        moves
//  request   req_push, req_full, req_char_byte            one character
//  response  rsp_pop, rsp_empty, rsp_command_*            one command per ';'
//  config    csr_write_enable, csr_index, csr_write_data  register write
//
//  One character is taken per cycle while req_full is low; the front end
//  classifies it into a command queue, and the back end retires one queue
//  entry per cycle; each command enters the response queue as its ';' is
//  taken. Reset empties both queues and loads the register reset values.
//  A ';' waits in the command queue while the response queue is full;
//  req_full rises once the command queue is full.
// ----------------------------------------------------------------------------
module text_command_line_parser_unit
   import tclp_pkg::*;
#(
   parameter int MAX_LINE  = 256,
   parameter int CMD_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_char_byte,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [3:0]         rsp_command_kind,
   output logic signed [31:0] rsp_command_value,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_write_data
);

   localparam int EntryW  = $bits(tclp_entry_type);
   localparam int ResultW = $bits(tclp_result_type);

   logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
   tclp_entry_type  cmd_in_entry, cmd_out_entry;
   logic            res_push, res_full;
   tclp_result_type res_in, res_out;

   assign req_full = cmd_full;

   // Classify characters
   tclp_front #(
      .MaxLine (MAX_LINE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_char_byte (req_char_byte),
      .queue_full    (cmd_full),
      .queue_push    (cmd_push),
      .queue_entry   (cmd_in_entry)
   );

   // Decouple front and back
   tclp_fifo #(
      .Width (EntryW),
      .Depth (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_entry),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_entry),
      .empty     (cmd_empty)
   );

   // Parse and build commands
   tclp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .entry_valid      (!cmd_empty),
      .entry            (cmd_out_entry),
      .entry_pop        (cmd_pop),
      .result_full      (res_full),
      .result_push      (res_push),
      .result           (res_in)
   );

   // Hold commands for the consumer
   tclp_fifo #(
      .Width (ResultW),
      .Depth (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign rsp_command_kind  = res_out.command_kind;
   assign rsp_command_value = res_out.command_value;

endmodule

// ===== rtl/tclp_checker.sv =====
// ----------------------------------------------------------------------------
// Command line parser checker
// Port-level checks on reset, command codes and command values.
// ----------------------------------------------------------------------------
`include "text_command_line_parser_unit_defines.svh"

module tclp_checker
   import tclp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic [3:0]  rsp_command_kind,
   input logic [31:0] rsp_command_value
);

   // Reset leaves nothing waiting and room for a request
   `TCLP_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)

   // Only defined command kinds leave the block
   `TCLP_ASSERT_IMPLY(a_kind_range, clock, reset, !rsp_empty, rsp_command_kind <= KIND_LAST)

   // Errors report minus one
   `TCLP_ASSERT_IMPLY(a_error_value, clock, reset,
      !rsp_empty && rsp_command_kind == KIND_ERROR, rsp_command_value == 32'hFFFF_FFFF)

   // Kinds without a number or id report minus one
   `TCLP_ASSERT_IMPLY(a_plain_value, clock, reset,
      !rsp_empty && rsp_command_kind != KIND_SPEED && rsp_command_kind != KIND_TARGET
         && rsp_command_kind != KIND_CHARGE,
      rsp_command_value == 32'hFFFF_FFFF)

endmodule

bind text_command_line_parser_unit tclp_checker u_tclp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_command_kind  (rsp_command_kind),
   .rsp_command_value (rsp_command_value)
);
